### hdl/ffed_pkg.sv
// Shared types and constants for the form field extract decoder.
// Used by the front parser, the result queue, the back end and the top level.
package ffed_pkg;

  // Most characters a key may have, and the width of the raw value counter.
  localparam int MAX_KEY_CHARS    = 8;
  localparam int VALUE_COUNT_BITS = 10;

  // Most results one input byte can cause, and the depth of the queue.
  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_BYTES  = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_VALUE  = 2'd2;

  // Characters with a meaning in the form body.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Configuration register file contents.
  typedef struct packed {
    logic [8*MAX_KEY_CHARS-1:0]  key_bytes;
    logic [3:0]                  key_length;
    logic [VALUE_COUNT_BITS-1:0] max_value_length;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       search_done;
    logic       key_found;
  } res_t;

  // All results of one input byte, entry 0 first.
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] ent;
    logic [RES_CNT_W-1:0]   cnt;
  } burst_t;

endpackage

### hdl/ffed_if.sv
// Valid/ready channel interfaces for the form bytes and the decoded results.
// Depends on nothing but the handshake convention: a transfer happens when valid and ready are high.
interface ffed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] form_byte;
  logic       form_end;

  modport source (output valid, output form_byte, output form_end, input ready);
  modport sink   (input valid, input form_byte, input form_end, output ready);
endinterface

interface ffed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       search_done;
  logic       key_found;
  logic       run_last;

  modport source (output valid, output value_byte, output byte_valid, output search_done,
                  output key_found, output run_last, input ready);
  modport sink   (input valid, input value_byte, input byte_valid, input search_done,
                  input key_found, input run_last, output ready);
endinterface

### hdl/ffed_front.sv
// Front end: accepts form bytes, runs the key/value parser and builds the results of each byte.
// Depends on ffed_pkg and ffed_in_if; feeds ffed_queue.
module ffed_front
  import ffed_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ffed_in_if.sink      form,
  input  cfg_t         cfg,
  input  logic         q_full,
  output logic         push,
  output burst_t       push_data
);

  // Parser phases.
  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Escape progress codes.
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  // Working record while the results of one byte are put together.
  typedef struct packed {
    burst_t     b;
    logic       stop;
    logic [1:0] esc;
  } build_t;

  logic [1:0]                  phase, phase_next;
  logic [3:0]                  key_pos, key_pos_next;
  logic                        key_match, key_match_next;
  logic [VALUE_COUNT_BITS-1:0] raw_cnt, raw_cnt_next;
  logic [1:0]                  esc, esc_next;
  logic [7:0]                  held, held_next;
  logic                        out_stop, out_stop_next;
  logic                        accept;
  burst_t                      burst;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Letters of either case share their low nibble plus nine.
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic build_t emit_res(build_t s, res_t r);
    build_t o;
    o = s;
    if (s.b.cnt < RES_CNT_W'(MAX_RESULTS)) begin
      o.b.ent[s.b.cnt[RES_IDX_W-1:0]] = r;
      o.b.cnt = s.b.cnt + RES_CNT_W'(1);
    end
    return o;
  endfunction

  // A decoded zero byte stops all further characters of this form.
  function automatic build_t put_char(build_t s, logic [7:0] c);
    build_t o;
    res_t   r;
    o = s;
    r.value_byte  = c;
    r.byte_valid  = 1'b1;
    r.search_done = 1'b0;
    r.key_found   = 1'b0;
    if (!s.stop) begin
      if (c == CH_NUL) begin
        o.stop = 1'b1;
      end else begin
        o = emit_res(s, r);
      end
    end
    return o;
  endfunction

  function automatic build_t plain_char(build_t s, logic [7:0] c);
    build_t o;
    o = s;
    if (c == CH_PLUS) begin
      o = put_char(s, CH_SPACE);
    end else if (c == CH_PCT) begin
      o.esc = ESC_PCT;
    end else begin
      o = put_char(s, c);
    end
    return o;
  endfunction

  assign form.ready = !q_full;
  assign accept     = form.valid && form.ready;
  assign push       = accept && (burst.cnt != '0);
  assign push_data  = burst;

  // Parser step for the byte on the input.
  always_comb begin
    build_t                      s;
    logic [7:0]                  c;
    logic [3:0]                  klen;
    logic                        term;
    res_t                        verdict;
    logic [1:0]                  ph;

    c    = form.form_byte;
    klen = (cfg.key_length > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : cfg.key_length;
    term = 1'b0;
    ph   = phase;

    key_pos_next   = key_pos;
    key_match_next = key_match;
    raw_cnt_next   = raw_cnt;
    held_next      = held;

    s.b    = '0;
    s.stop = out_stop;
    s.esc  = esc;

    if (c == CH_NUL && phase != PH_DONE) begin
      term = 1'b1;
    end else begin
      unique case (phase)
        PH_KEY: begin
          if (c == CH_EQ) begin
            if (key_match && key_pos == klen) begin
              ph           = PH_VALUE;
              raw_cnt_next = '0;
              s.esc        = ESC_NONE;
              s.stop       = 1'b0;
            end else begin
              ph = PH_SKIP;
            end
          end else if (key_pos < klen && key_pos < 4'(MAX_KEY_CHARS) &&
                       c == cfg.key_bytes[{key_pos[2:0], 3'b000} +: 8]) begin
            key_pos_next = key_pos + 4'd1;
          end else begin
            key_match_next = 1'b0;
          end
        end
        PH_SKIP: begin
          if (c == CH_AMP) begin
            ph             = PH_KEY;
            key_pos_next   = '0;
            key_match_next = 1'b1;
          end
        end
        PH_VALUE: begin
          if (c == CH_AMP) begin
            term = 1'b1;
          end else if (raw_cnt < cfg.max_value_length) begin
            raw_cnt_next = raw_cnt + VALUE_COUNT_BITS'(1);
            if (esc == ESC_PCT) begin
              if (is_hex(c)) begin
                held_next = c;
                s.esc     = ESC_HEX;
              end else begin
                s     = put_char(s, CH_PCT);
                s.esc = ESC_NONE;
                s     = plain_char(s, c);
              end
            end else if (esc == ESC_HEX) begin
              if (is_hex(c)) begin
                s.esc = ESC_NONE;
                s     = put_char(s, {hex_val(held), hex_val(c)});
              end else begin
                s     = put_char(s, CH_PCT);
                s     = put_char(s, held);
                s.esc = ESC_NONE;
                s     = plain_char(s, c);
              end
            end else begin
              s = plain_char(s, c);
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    // End of the value or of the body: flush a pending escape, then the verdict.
    verdict.value_byte  = '0;
    verdict.byte_valid  = 1'b0;
    verdict.search_done = 1'b1;
    verdict.key_found   = (ph == PH_VALUE);
    if (term || form.form_end) begin
      if (ph == PH_VALUE) begin
        if (s.esc == ESC_PCT) begin
          s = put_char(s, CH_PCT);
        end else if (s.esc == ESC_HEX) begin
          s = put_char(s, CH_PCT);
          s = put_char(s, held_next);
        end
        s.esc = ESC_NONE;
        s     = emit_res(s, verdict);
      end else if (ph != PH_DONE) begin
        s = emit_res(s, verdict);
      end
      ph = PH_DONE;
    end

    burst         = s.b;
    phase_next    = ph;
    esc_next      = s.esc;
    out_stop_next = s.stop;

    // The last byte of a body leaves the parser as after reset.
    if (form.form_end) begin
      phase_next     = PH_KEY;
      key_pos_next   = '0;
      key_match_next = 1'b1;
      raw_cnt_next   = '0;
      esc_next       = ESC_NONE;
      held_next      = '0;
      out_stop_next  = 1'b0;
    end
  end

  // Parser state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_KEY;
      key_pos   <= '0;
      key_match <= 1'b1;
      raw_cnt   <= '0;
      esc       <= ESC_NONE;
      held      <= '0;
      out_stop  <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      key_pos   <= key_pos_next;
      key_match <= key_match_next;
      raw_cnt   <= raw_cnt_next;
      esc       <= esc_next;
      held      <= held_next;
      out_stop  <= out_stop_next;
    end
  end

endmodule

### hdl/ffed_queue.sv
// Short queue of result groups between the front parser and the back end.
// Depends on ffed_pkg.
module ffed_queue
  import ffed_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output burst_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  burst_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

### hdl/ffed_back.sv
// Back end: holds one result group and hands its entries to the output channel one per transfer.
// Depends on ffed_pkg, ffed_out_if and the head of ffed_queue.
module ffed_back
  import ffed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  burst_t     head,
  input  logic       q_empty,
  output logic       pop,
  ffed_out_if.source value
);

  burst_t               cur;
  logic [RES_IDX_W-1:0] idx;
  logic                 busy;
  logic                 last;
  logic                 xfer;
  res_t                 r;

  assign r    = cur.ent[idx];
  assign last = (RES_CNT_W'(idx) + RES_CNT_W'(1) == cur.cnt);
  assign xfer = busy && value.ready;

  // Take the next group when idle or when the last entry of this one transfers.
  assign pop = !q_empty && (!busy || (xfer && last));

  assign value.valid       = busy;
  assign value.value_byte  = r.value_byte;
  assign value.byte_valid  = r.byte_valid;
  assign value.search_done = r.search_done;
  assign value.key_found   = r.key_found;
  assign value.run_last    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
      end
      idx <= idx + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

### hdl/form_field_extract_decoder.sv
// Top level of the form field extract decoder: configuration registers, front parser,
// result queue and back end. Depends on ffed_pkg, ffed_if, ffed_front, ffed_queue, ffed_back.
//
// Usage: form bytes arrive on the form channel, one byte per transfer, with form_end on the
// last byte of a body. Decoded value characters and one verdict item per body leave on the
// value channel; run_last marks the last result that a byte caused. A byte may cause no
// result at all, or up to four (a broken escape, the byte that broke it and the verdict).
// Configuration is written through cfg_write, cfg_index and cfg_data while the block is idle:
// index 0 is the key characters, 1 the key length, 2 the raw value length limit.
// The first result of a byte is written into the result queue when the byte transfers and
// becomes valid on the value channel once the back end has loaded its group register.
// Bytes flow at one per cycle while each gives at most one result and the receiver is ready;
// a byte with more results holds the back end's single group register until each has transferred.
// The front parser does one byte per cycle; a four-entry queue of result groups lets it keep
// taking bytes while the receiver stalls, and form.ready drops only once that queue is full.
// Reset (rst, synchronous) empties the queue and the output, returns the parser to the key
// phase, and sets the registers to an empty key and a limit of 32 raw value bytes.
module form_field_extract_decoder
  import ffed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ffed_in_if.sink     form,
  ffed_out_if.source  value,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  burst_t push_data;
  logic   pop;
  burst_t head;
  logic   q_full;
  logic   q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_bytes        <= '0;
      cfg.key_length       <= '0;
      cfg.max_value_length <= VALUE_COUNT_BITS'(32);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY_BYTES:  cfg.key_bytes        <= cfg_data[8*MAX_KEY_CHARS-1:0];
        CFG_KEY_LENGTH: cfg.key_length       <= cfg_data[3:0];
        CFG_MAX_VALUE:  cfg.max_value_length <= cfg_data[VALUE_COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  ffed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .form      (form),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ffed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  ffed_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .value   (value)
  );

  // The front never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("result queue overflow");

  // A verdict is always the last result of its byte.
  assert property (@(posedge clk) disable iff (rst)
                   (value.valid && value.search_done) |-> value.run_last)
    else $error("verdict not last in its run");

  // A result carries a character or a verdict, never both.
  assert property (@(posedge clk) disable iff (rst)
                   value.valid |-> !(value.byte_valid && value.search_done))
    else $error("result is both character and verdict");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk) disable iff (rst) !(pop && q_empty))
    else $error("result queue underflow");

endmodule
